// ----- hdl/framed_uart_packet_receiver_unit_macros.svh -----
// Assertion helpers shared by the receiver RTL.
`ifndef FRAMED_UART_PACKET_RECEIVER_UNIT_MACROS_SVH
`define FRAMED_UART_PACKET_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FRP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/frp_pkg.sv -----
package frp_pkg;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_SYNC2   = 3'd1;
   localparam logic [2:0] PH_LEN_HI  = 3'd2;
   localparam logic [2:0] PH_LEN_LO  = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_CRC     = 3'd5;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_BYTE    = 3'd1;
   localparam logic [2:0] EV_GOOD    = 3'd2;
   localparam logic [2:0] EV_CRCERR  = 3'd3;
   localparam logic [2:0] EV_TIMEOUT = 3'd4;
   localparam logic [2:0] EV_LENREJ  = 3'd5;

   localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
   localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
   localparam logic [1:0] REG_MAX_LEN     = 2'd2;

   localparam logic [15:0] MAX_LEN_RESET = 16'd1200;
   localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
   localparam logic [2:0]  CRC_BYTES     = 3'd4;

   typedef struct packed {
      logic [7:0]  sync_first;
      logic [7:0]  sync_second;
      logic [15:0] max_payload_length;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  rx_phase;
      logic [15:0] frame_len;
      logic [15:0] bytes_left;
      logic [31:0] running_crc;
      logic [31:0] received_crc;
      logic [2:0]  crc_bytes_left;
      logic [31:0] good_frames;
      logic [31:0] crc_errors;
      logic [31:0] timeouts;
   } chan_state_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  payload_byte;
      logic [15:0] frame_length;
   } step_result_type;

   function automatic chan_state_type chan_reset_state();
      chan_state_type s;
      s                = '0;
      s.rx_phase       = PH_IDLE;
      s.running_crc    = CRC_INIT;
      return s;
   endfunction

   // Reflected CRC-32, one byte, LSB first.
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- hdl/frp_chan_bank.sv -----
module frp_chan_bank #(
   parameter int NUM_CHANNELS = 4,
   parameter int IDX_W        = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_idx,
   input  frp_pkg::chan_state_type wr_state,
   input  logic [IDX_W-1:0]        rd_idx,
   output frp_pkg::chan_state_type rd_state
);
   import frp_pkg::*;

   chan_state_type bank_ff [NUM_CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            bank_ff[i] <= chan_reset_state();
         end
      end else if (wr_en) begin
         bank_ff[wr_idx] <= wr_state;
      end
   end

   assign rd_state = bank_ff[rd_idx];

endmodule

// ----- hdl/frp_step.sv -----
module frp_step (
   input  frp_pkg::cfg_type         cfg,
   input  logic                     mode,
   input  logic [7:0]               data_byte,
   input  frp_pkg::chan_state_type  cur,
   output frp_pkg::chan_state_type  nxt,
   output frp_pkg::step_result_type res
);
   import frp_pkg::*;

   logic [15:0] len_full;
   logic [15:0] bl_dec;
   logic [2:0]  cl_dec;
   logic [31:0] rcv_acc;
   logic [31:0] crc_upd;

   assign len_full = cur.frame_len | {8'd0, data_byte};
   assign bl_dec   = (cur.bytes_left != 16'd0) ? cur.bytes_left - 16'd1 : cur.bytes_left;
   assign cl_dec   = (cur.crc_bytes_left != 3'd0) ? cur.crc_bytes_left - 3'd1 : 3'd0;
   assign rcv_acc  = cur.received_crc | ({24'd0, data_byte} << {cl_dec[1:0], 3'b000});
   assign crc_upd  = crc32_byte(cur.running_crc, data_byte);

   always_comb begin
      nxt              = cur;
      res.event_res    = EV_NONE;
      res.payload_byte = 8'd0;
      res.frame_length = 16'd0;
      if (mode) begin
         // Timeout: abort any frame in progress, ignore in idle.
         if (cur.rx_phase inside {[PH_SYNC2:PH_CRC]}) begin
            if (cur.rx_phase == PH_PAYLOAD || cur.rx_phase == PH_CRC) begin
               res.frame_length = cur.frame_len;
            end
            nxt.timeouts  = cur.timeouts + 32'd1;
            res.event_res = EV_TIMEOUT;
         end
         nxt.rx_phase = PH_IDLE;
      end else begin
         case (cur.rx_phase)
            PH_SYNC2: begin
               if (data_byte == cfg.sync_second) begin
                  nxt.rx_phase = PH_LEN_HI;
               end else begin
                  nxt.timeouts  = cur.timeouts + 32'd1;
                  res.event_res = EV_TIMEOUT;
                  nxt.rx_phase  = PH_IDLE;
               end
            end
            PH_LEN_HI: begin
               nxt.frame_len = {data_byte, 8'd0};
               nxt.rx_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               nxt.frame_len      = len_full;
               nxt.running_crc    = CRC_INIT;
               nxt.crc_bytes_left = CRC_BYTES;
               if (len_full == 16'd0 || len_full > cfg.max_payload_length) begin
                  res.event_res    = EV_LENREJ;
                  res.frame_length = len_full;
                  nxt.rx_phase     = PH_IDLE;
               end else begin
                  nxt.bytes_left = len_full;
                  nxt.rx_phase   = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               nxt.running_crc  = crc_upd;
               res.event_res    = EV_BYTE;
               res.payload_byte = data_byte;
               nxt.bytes_left   = bl_dec;
               if (bl_dec == 16'd0) begin
                  nxt.crc_bytes_left = CRC_BYTES;
                  nxt.received_crc   = 32'd0;
                  nxt.rx_phase       = PH_CRC;
               end
            end
            PH_CRC: begin
               nxt.crc_bytes_left = cl_dec;
               nxt.received_crc   = rcv_acc;
               if (cl_dec == 3'd0) begin
                  res.frame_length = cur.frame_len;
                  if (rcv_acc == ~cur.running_crc) begin
                     nxt.good_frames = cur.good_frames + 32'd1;
                     res.event_res   = EV_GOOD;
                  end else begin
                     nxt.crc_errors = cur.crc_errors + 32'd1;
                     res.event_res  = EV_CRCERR;
                  end
                  nxt.rx_phase = PH_IDLE;
               end
            end
            default: begin
               // Idle and unused codes: hunt for the first sync byte.
               nxt.rx_phase = (data_byte == cfg.sync_first) ? PH_SYNC2 : PH_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- hdl/framed_uart_packet_receiver_unit.sv -----
// Framed serial packet receiver: one shared deframer step with per-channel state.
// Input channel (req_): one transaction per received byte or per
// inter-character timeout event, tagged with its channel. A frame is two sync
// bytes, a big-endian 16-bit length, the payload and a big-endian CRC-32.
// Result channel (rsp_): exactly one transaction per input transaction, in
// order: an event code, the streamed payload byte, the frame length on end
// events and the channel's good, CRC-error and timeout counters.
// Path: an accepted input is held in the input register and then moved to the
// result register, where the result becomes valid. Throughput: one transaction per
// cycle while rsp_tready is high, back to back, also on the same channel; the
// per-channel state is written at the same edge that loads the result, so the next
// item always sees the updated state.
// Stall: when rsp_tready is low the result register holds, the input register
// fills and then req_tready drops; nothing is lost or repeated.
// Reset (synchronous, active high): all channels go idle, CRCs to all ones,
// counters to zero, sync bytes to zero and the length limit to 1200. No
// clearing pass is needed; the block accepts data as soon as reset is released.
// The user must write configuration (csr_) only while the block holds no item; the block does not enforce this.
module framed_uart_packet_receiver_unit #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic         clock,
   input  logic         reset,
   // Configuration write port.
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   // Input stream.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // [1:0] channel, [9:2] data_byte, rest zero
   input  logic [0:0]   req_tuser,   // [0] mode (1 = timeout event)
   // Result stream.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [1:0] out_channel, [9:2] payload_byte,
                                     // [25:10] frame_length, [57:26] good_count,
                                     // [89:58] crc_error_count,
                                     // [121:90] timeout_count, rest zero
   output logic [2:0]   rsp_tuser    // [2:0] event_res
);
   import frp_pkg::*;

`include "framed_uart_packet_receiver_unit_macros.svh"

   localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // Configuration registers.
   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SYNC_FIRST:  cfg_in.sync_first         = csr_wdata[7:0];
            REG_SYNC_SECOND: cfg_in.sync_second        = csr_wdata[7:0];
            REG_MAX_LEN:     cfg_in.max_payload_length = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first         <= 8'd0;
         cfg_ff.sync_second        <= 8'd0;
         cfg_ff.max_payload_length <= MAX_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register.
   logic       in_valid_ff;
   logic [1:0] in_chan_ff;
   logic       in_mode_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   logic       advance;
   logic       chan_ok;

   // Move the held item into the result register whenever that register frees.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign chan_ok    = (32'(in_chan_ff) < NUM_CHANNELS);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_chan_ff <= req_tdata[1:0];
         in_byte_ff <= req_tdata[9:2];
         in_mode_ff <= req_tuser[0];
      end
   end

   // Per-channel state and the single-pass update.
   chan_state_type  cur_state;
   chan_state_type  nxt_state;
   step_result_type step_res;

   frp_chan_bank #(
      .NUM_CHANNELS(NUM_CHANNELS),
      .IDX_W       (IdxW)
   ) u_bank (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (advance && chan_ok),
      .wr_idx  (IdxW'(in_chan_ff)),
      .wr_state(nxt_state),
      .rd_idx  (IdxW'(in_chan_ff)),
      .rd_state(cur_state)
   );

   frp_step u_step (
      .cfg      (cfg_ff),
      .mode     (in_mode_ff),
      .data_byte(in_byte_ff),
      .cur      (cur_state),
      .nxt      (nxt_state),
      .res      (step_res)
   );

   // Result register.
   logic [1:0]  rsp_chan_ff;
   logic [2:0]  rsp_event_ff;
   logic [7:0]  rsp_byte_ff;
   logic [15:0] rsp_len_ff;
   logic [31:0] rsp_good_ff;
   logic [31:0] rsp_crcerr_ff;
   logic [31:0] rsp_tmo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_chan_ff <= in_chan_ff;
         if (chan_ok) begin
            rsp_event_ff  <= step_res.event_res;
            rsp_byte_ff   <= step_res.payload_byte;
            rsp_len_ff    <= step_res.frame_length;
            rsp_good_ff   <= nxt_state.good_frames;
            rsp_crcerr_ff <= nxt_state.crc_errors;
            rsp_tmo_ff    <= nxt_state.timeouts;
         end else begin
            // Drop items for channels that do not exist: empty result.
            rsp_event_ff  <= EV_NONE;
            rsp_byte_ff   <= 8'd0;
            rsp_len_ff    <= 16'd0;
            rsp_good_ff   <= 32'd0;
            rsp_crcerr_ff <= 32'd0;
            rsp_tmo_ff    <= 32'd0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = rsp_event_ff;
   assign rsp_tdata  = {6'd0, rsp_tmo_ff, rsp_crcerr_ff, rsp_good_ff,
                        rsp_len_ff, rsp_byte_ff, rsp_chan_ff};

   // Checks.
   logic        stalled;
   logic        bad_hit;
   logic        good_hit;
   logic        rsp_empty;
   logic [31:0] good_inc;

   assign stalled   = out_valid_ff && !rsp_tready;
   assign bad_hit   = advance && !chan_ok;
   assign good_hit  = advance && chan_ok && (step_res.event_res == EV_GOOD);
   assign rsp_empty = (rsp_tuser == EV_NONE) && (rsp_tdata[121:2] == '0);
   assign good_inc  = cur_state.good_frames + 32'd1;

   `FRP_ASSERT_NOW(a_no_overwrite, clock, reset, stalled, !advance, "result overwritten")
   `FRP_ASSERT_NEXT(a_bad_chan_empty, clock, reset, bad_hit, rsp_empty, "bad channel result")
   `FRP_ASSERT_NEXT(a_good_inc, clock, reset, good_hit, rsp_good_ff == $past(good_inc), "good miss")

endmodule
